FILE: rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and sizes for the double-ended queue core.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY   = 256;
    localparam int WORD_WIDTH = 32;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W   = COUNT_W + 1;

    localparam int REQ_W  = 4;
    localparam int POS_W  = 8;
    localparam int WIN_W  = 32;
    localparam int WOUT_W = 32;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 9;

    localparam logic [REQ_W-1:0] OP_PUSH_HEAD = 4'd0;
    localparam logic [REQ_W-1:0] OP_PUSH_TAIL = 4'd1;
    localparam logic [REQ_W-1:0] OP_POP_HEAD  = 4'd2;
    localparam logic [REQ_W-1:0] OP_POP_TAIL  = 4'd3;
    localparam logic [REQ_W-1:0] OP_PEEK_HEAD = 4'd4;
    localparam logic [REQ_W-1:0] OP_PEEK_TAIL = 4'd5;
    localparam logic [REQ_W-1:0] OP_GET       = 4'd6;
    localparam logic [REQ_W-1:0] OP_SET       = 4'd7;
    localparam logic [REQ_W-1:0] OP_CLEAR     = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] position;
        logic [WIN_W-1:0] word_in;
    } t_req_beat;

    typedef struct packed {
        logic [WOUT_W-1:0] word_out;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp_beat;

    // What one request does to the store and to the ring pointers.
    typedef struct packed {
        logic                  rd;        // read the slot at accept
        logic                  wr_now;    // write the slot at accept (push)
        logic                  wr_later;  // write the slot after the read (set)
        logic [SLOT_W-1:0]     slot;
        logic [WORD_WIDTH-1:0] wdata;
        logic [STAT_W-1:0]     status;
        logic [SLOT_W-1:0]     new_head;
        logic [COUNT_W-1:0]    new_count;
    } t_plan;

endpackage

FILE: rtl/dq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_store
// Single-port ring store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module dq_store (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [dq_pkg::SLOT_W-1:0]     i_addr,
    input  logic [dq_pkg::WORD_WIDTH-1:0] i_wdata,
    output logic [dq_pkg::WORD_WIDTH-1:0] o_rdata
);
    import dq_pkg::*;

    logic [WORD_WIDTH-1:0] r_mem [CAPACITY];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dq_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_decode
// Request decode: status checks, slot address and next head and count.
// ----------------------------------------------------------------------------
module dq_decode (
    input  dq_pkg::t_req_beat            i_req,
    input  logic [dq_pkg::SLOT_W-1:0]    i_head,
    input  logic [dq_pkg::COUNT_W-1:0]   i_count,
    output dq_pkg::t_plan                o_plan
);
    import dq_pkg::*;

    logic [WORD_WIDTH-1:0] word;
    logic                  word_nz;
    logic [COUNT_W-1:0]    pos;
    logic [COUNT_W-1:0]    offset;
    logic [SUM_W-1:0]      sum;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_W-1:0]     head_next;
    t_plan                 plan;

    assign word    = i_req.word_in[WORD_WIDTH-1:0];
    assign word_nz = |word;
    assign pos     = COUNT_W'(i_req.position);

    // Pick the offset from the head that this request addresses.
    always_comb begin
        case (i_req.req_type)
            OP_PUSH_HEAD: offset = COUNT_W'(CAPACITY - 1);
            OP_PUSH_TAIL: offset = i_count;
            OP_POP_TAIL,
            OP_PEEK_TAIL: offset = i_count - COUNT_W'(1);
            OP_GET,
            OP_SET:       offset = pos;
            default:      offset = '0;
        endcase
    end

    // Wrap: offset is at most capacity for any request that uses the slot, so one subtract is enough.
    assign sum  = SUM_W'(i_head) + SUM_W'(offset);
    assign slot = (sum >= SUM_W'(CAPACITY)) ? SLOT_W'(sum - SUM_W'(CAPACITY))
                                             : SLOT_W'(sum);

    assign head_next = (i_head == SLOT_W'(CAPACITY - 1)) ? '0 : i_head + SLOT_W'(1);

    always_comb begin
        plan           = '0;
        plan.slot      = slot;
        plan.wdata     = word;
        plan.status    = ST_OK;
        plan.new_head  = i_head;
        plan.new_count = i_count;
        case (i_req.req_type)
            OP_PUSH_HEAD,
            OP_PUSH_TAIL: begin
                if (!word_nz) begin
                    plan.status = ST_ZERO;
                end else if (i_count >= COUNT_W'(CAPACITY)) begin
                    plan.status = ST_FULL;
                end else begin
                    plan.wr_now    = 1'b1;
                    plan.new_count = i_count + COUNT_W'(1);
                    if (i_req.req_type == OP_PUSH_HEAD) begin
                        plan.new_head = slot;
                    end
                end
            end
            OP_POP_HEAD,
            OP_PEEK_HEAD,
            OP_POP_TAIL,
            OP_PEEK_TAIL: begin
                if (i_count == '0) begin
                    plan.status = ST_EMPTY;
                end else begin
                    plan.rd = 1'b1;
                    if (i_req.req_type == OP_POP_HEAD) begin
                        plan.new_head  = head_next;
                        plan.new_count = i_count - COUNT_W'(1);
                    end else if (i_req.req_type == OP_POP_TAIL) begin
                        plan.new_count = i_count - COUNT_W'(1);
                    end
                end
            end
            OP_GET: begin
                if (pos >= i_count) begin
                    plan.status = ST_RANGE;
                end else begin
                    plan.rd = 1'b1;
                end
            end
            OP_SET: begin
                if (!word_nz) begin
                    plan.status = ST_ZERO;
                end else if (pos >= i_count) begin
                    plan.status = ST_RANGE;
                end else begin
                    plan.rd       = 1'b1;
                    plan.wr_later = 1'b1;
                end
            end
            OP_CLEAR: begin
                plan.new_head  = '0;
                plan.new_count = '0;
            end
            default: begin
                plan.status = ST_OK;
            end
        endcase
    end

    assign o_plan = plan;

endmodule

FILE: rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of nonzero words in a single-port ring store.
// ----------------------------------------------------------------------------
//
//  channel   valid     ready     payload   direction
//  request   i_valid   o_ready   i_req     in
//  response  o_valid   i_ready   o_rsp     out
//
//  Every request passes through S_IDLE, the accept state, in which the store is
//  read (or written, for a push), and S_READ, which takes the registered read
//  data of the store port and in which a set writes its new word back.
//  Reset clears head, count and the response valid; the store itself is left as it is.
//  A new request is taken while the previous response still waits; it holds
//  in S_READ only while the response register is still full.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dq_pkg::t_req_beat i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output dq_pkg::t_rsp_beat o_rsp
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_head;
    logic [COUNT_W-1:0] r_count;
    t_plan              r_plan;
    logic               r_out_valid, n_out_valid;
    t_rsp_beat          r_rsp;

    t_plan                 plan;
    logic                  accept;
    logic                  finish;
    logic                  mem_en;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_addr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [WORD_WIDTH-1:0] mem_rdata;

    dq_decode u_decode (
        .i_req   (i_req),
        .i_head  (r_head),
        .i_count (r_count),
        .o_plan  (plan)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    // Leave S_READ once the response register can take the beat.
    assign finish  = (r_state == S_READ) && (!r_out_valid || i_ready);

    // One store access a cycle: the decoded one at accept, the set write-back
    // as the request finishes.
    always_comb begin
        if (r_state == S_READ) begin
            mem_en    = finish && r_plan.wr_later;
            mem_we    = 1'b1;
            mem_addr  = r_plan.slot;
            mem_wdata = r_plan.wdata;
        end else begin
            mem_en    = accept && (plan.rd || plan.wr_now);
            mem_we    = plan.wr_now;
            mem_addr  = plan.slot;
            mem_wdata = plan.wdata;
        end
    end

    dq_store u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            // Advance the ring pointers as the request is taken.
            if (accept) begin
                r_head  <= plan.new_head;
                r_count <= plan.new_count;
            end
        end
    end

    // Hold the plan for S_READ; build the response beat from it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plan <= plan;
        end
        if (finish) begin
            r_rsp.word_out  <= r_plan.rd ? WOUT_W'(mem_rdata) : '0;
            r_rsp.status    <= r_plan.status;
            r_rsp.occupancy <= OCC_W'(r_plan.new_count);
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule
